@@ src/xrng_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xrng_pkg;

  localparam logic [63:0] SEED_RESET = 64'd88172645463325252;

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 17;

  // remainder unit step counts
  localparam logic [6:0] MOD_STEPS_WIDE   = 7'd64;
  localparam logic [6:0] MOD_STEPS_NARROW = 7'd32;
  localparam logic [6:0] MOD_STEPS_LETTER = 7'd2;

  // ceil(2^34 / 13), exact quotient by 13 for 30-bit values
  localparam logic [30:0] LETTER_RECIP      = 31'h4EC4EC4F;
  localparam logic [5:0]  ALPHABET_HALF     = 6'd26;
  localparam logic [7:0]  LETTER_LOWER_BASE = 8'h61;
  localparam logic [7:0]  LETTER_UPPER_BASE = 8'h41;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_RAW64    = 3'd0,
    CMD_RAW32    = 3'd1,
    CMD_RANGED32 = 3'd2,
    CMD_RANGED64 = 3'd3,
    CMD_LETTERS  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_RAW64,
    OP_RAW32,
    OP_MOD32,
    OP_MOD64,
    OP_LETTERS,
    OP_CONST
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] lo;
    logic [63:0] span;
    logic [6:0]  count;
  } op_t;

  typedef struct packed {
    logic        start;
    logic        wide;
    logic        letter;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] rem;
  } mod_rsp_t;

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    logic [63:0] t;
    t = x ^ (x << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

  function automatic logic [7:0] letter_code(input logic [5:0] idx);
    logic [7:0] r;
    if (idx < ALPHABET_HALF) begin
      r = LETTER_LOWER_BASE + {2'b00, idx};
    end else begin
      r = LETTER_UPPER_BASE + {2'b00, idx - ALPHABET_HALF};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/xrng_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xrng_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [6:0]  letter_count;

  modport source (output valid, output cmd, output range_low, output range_high,
                  output letter_count, input ready);
  modport sink (input valid, input cmd, input range_low, input range_high,
                input letter_count, output ready);
endinterface

`default_nettype wire

@@ src/xrng_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xrng_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

@@ src/xrng_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xrng_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/xorshift64_range_rng_top.sv @@
// channel  | dir | payload                                      | request
// ---------+-----+----------------------------------------------+------------------------
// cmd_i    | in  | cmd, range_low, range_high, letter_count     | one command
// res_o    | out | value, last                                  | one result
// cfg_i    | in  | data (seed)                                  | one seed write
//
// raw draws and equal-bound ranged draws: queue head to a pending register, then the
// output register; ranged32 and ranged64 draws first pass the bit-serial remainder
// unit (one dividend bit per cycle); each letter passes a two-step reciprocal
// remainder by 52
// reset loads the generator with the default seed, no clearing pass
// a 2-deep command queue and an output register let each side stall on its own
`timescale 1ns / 1ps
`default_nettype none

module xorshift64_range_rng_top #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  xrng_cmd_if.sink    cmd_i,
  xrng_res_if.source  res_o,
  xrng_cfg_if.sink    cfg_i
);

  logic               push, q_full, q_empty, pop;
  xrng_pkg::op_t      entry, head;
  xrng_pkg::mod_req_t mod_req;
  xrng_pkg::mod_rsp_t mod_rsp;

  xrng_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (entry)
  );

  xrng_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  xrng_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  xrng_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (head),
    .pop_o     (pop),
    .mod_req_o (mod_req),
    .mod_rsp_i (mod_rsp),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("command queue written while full");

  a_unknown_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && (cmd_i.cmd > 3'(xrng_pkg::CMD_LETTERS))) |-> !push)
    else $error("unknown command reached the queue");

  a_mod_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mod_req.start && mod_rsp.busy))
    else $error("remainder unit restarted while busy");
`endif

endmodule

`default_nettype wire

@@ src/xrng_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrng_front #(
  parameter int unsigned MAX_BURST = 64
) (
  xrng_cmd_if.sink          cmd_i,
  input  logic              q_full_i,
  output logic              push_o,
  output xrng_pkg::op_t     entry_o
);

  localparam logic [6:0] BurstMax = 7'(MAX_BURST);

  logic keep;

  always_comb begin
    entry_o       = '0;
    entry_o.op    = xrng_pkg::OP_RAW64;
    keep          = 1'b0;
    unique case (xrng_pkg::cmd_e'(cmd_i.cmd))
      xrng_pkg::CMD_RAW64: begin
        entry_o.op = xrng_pkg::OP_RAW64;
        keep       = 1'b1;
      end
      xrng_pkg::CMD_RAW32: begin
        entry_o.op = xrng_pkg::OP_RAW32;
        keep       = 1'b1;
      end
      xrng_pkg::CMD_RANGED32: begin
        keep       = 1'b1;
        entry_o.lo = {32'b0, cmd_i.range_low[31:0]};
        // equal bounds give the low bound with no draw
        if (cmd_i.range_low[31:0] == cmd_i.range_high[31:0]) begin
          entry_o.op = xrng_pkg::OP_CONST;
        end else begin
          entry_o.op   = xrng_pkg::OP_MOD32;
          entry_o.span = {32'b0, cmd_i.range_high[31:0] - cmd_i.range_low[31:0]};
        end
      end
      xrng_pkg::CMD_RANGED64: begin
        keep       = 1'b1;
        entry_o.lo = cmd_i.range_low;
        if (cmd_i.range_low == cmd_i.range_high) begin
          entry_o.op = xrng_pkg::OP_CONST;
        end else begin
          entry_o.op   = xrng_pkg::OP_MOD64;
          entry_o.span = cmd_i.range_high - cmd_i.range_low;
        end
      end
      xrng_pkg::CMD_LETTERS: begin
        entry_o.op    = xrng_pkg::OP_LETTERS;
        entry_o.count = (cmd_i.letter_count > BurstMax) ? BurstMax : cmd_i.letter_count;
        // empty burst is dropped
        keep          = (cmd_i.letter_count != 7'd0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_i.ready = !q_full_i;
  assign push_o      = cmd_i.valid && !q_full_i && keep;

endmodule

`default_nettype wire

@@ src/xrng_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrng_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xrng_pkg::op_t     push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output xrng_pkg::op_t     head_o
);

  localparam int unsigned Depth = xrng_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  xrng_pkg::op_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/xrng_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrng_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xrng_pkg::mod_req_t   req_i,
  output xrng_pkg::mod_rsp_t   rsp_o
);

  logic        busy_q, done_q, letter_q;
  logic [6:0]  cnt_q;
  logic [63:0] rem_q, dvd_q, dvs_q;
  logic [26:0] quo_q;
  logic [64:0] trial, diff;
  logic        fits;
  logic [60:0] prod;
  logic [29:0] quo_x13;
  logic [3:0]  quarter_rem;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // letters: x mod 52 = 4 * ((x >> 2) mod 13) + x[1:0]
  assign prod        = {31'b0, dvd_q[31:2]} * {30'b0, xrng_pkg::LETTER_RECIP};
  assign quo_x13     = {quo_q, 3'b000} + {1'b0, quo_q, 2'b00} + {3'b000, quo_q};
  assign quarter_rem = 4'(dvd_q[31:2] - quo_x13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      letter_q <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      dvd_q    <= '0;
      dvs_q    <= '0;
      quo_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        letter_q <= req_i.letter;
        cnt_q    <= req_i.letter ? xrng_pkg::MOD_STEPS_LETTER :
                    (req_i.wide ? xrng_pkg::MOD_STEPS_WIDE : xrng_pkg::MOD_STEPS_NARROW);
        rem_q    <= '0;
        dvd_q    <= req_i.dividend;
        dvs_q    <= req_i.divisor;
      end else if (busy_q) begin
        if (letter_q) begin
          if (cnt_q == xrng_pkg::MOD_STEPS_LETTER) begin
            quo_q <= prod[60:34];
          end else begin
            rem_q <= {58'b0, quarter_rem, dvd_q[1:0]};
          end
        end else begin
          rem_q <= fits ? diff[63:0] : trial[63:0];
          dvd_q <= {dvd_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ src/xrng_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrng_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  xrng_pkg::op_t        q_head_i,
  output logic                 pop_o,
  output xrng_pkg::mod_req_t   mod_req_o,
  input  xrng_pkg::mod_rsp_t   mod_rsp_i,
  xrng_cfg_if.sink             cfg_i,
  xrng_res_if.source           res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EMIT
  } state_e;

  state_e        state_q;
  xrng_pkg::op_e op_q;
  logic [63:0]   gen_q;
  logic [63:0]   lo_q;
  logic [6:0]    left_q;
  logic [63:0]   pend_value_q;
  logic          pend_last_q;
  logic          out_valid_q;
  logic [63:0]   out_value_q;
  logic          out_last_q;

  logic [63:0] xs_next;
  logic [63:0] mod_value;
  logic        out_free;
  logic        more;

  assign xs_next  = xrng_pkg::xorshift(gen_q);
  assign out_free = !out_valid_q || res_o.ready;
  assign more     = (op_q == xrng_pkg::OP_LETTERS) && (left_q > 7'd1);
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    unique case (op_q)
      xrng_pkg::OP_MOD64: mod_value = mod_rsp_i.rem + lo_q;
      xrng_pkg::OP_MOD32: mod_value = {32'b0, mod_rsp_i.rem[31:0] + lo_q[31:0]};
      default:            mod_value = {56'b0, xrng_pkg::letter_code(mod_rsp_i.rem[5:0])};
    endcase
  end

  // remainder requests use the freshly advanced state
  always_comb begin
    mod_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_head_i.op)
            xrng_pkg::OP_MOD64: begin
              mod_req_o.start    = 1'b1;
              mod_req_o.wide     = 1'b1;
              mod_req_o.dividend = xs_next;
              mod_req_o.divisor  = q_head_i.span;
            end
            xrng_pkg::OP_MOD32: begin
              mod_req_o.start    = 1'b1;
              mod_req_o.dividend = {xs_next[31:0], 32'b0};
              mod_req_o.divisor  = q_head_i.span;
            end
            xrng_pkg::OP_LETTERS: begin
              mod_req_o.start    = 1'b1;
              mod_req_o.letter   = 1'b1;
              mod_req_o.dividend = {32'b0, xs_next[31:0]};
            end
            default: begin
              mod_req_o.start = 1'b0;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free && more) begin
          mod_req_o.start    = 1'b1;
          mod_req_o.letter   = 1'b1;
          mod_req_o.dividend = {32'b0, xs_next[31:0]};
        end
      end
      default: begin
        mod_req_o.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= xrng_pkg::OP_RAW64;
      gen_q        <= xrng_pkg::SEED_RESET;
      lo_q         <= '0;
      left_q       <= '0;
      pend_value_q <= '0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            op_q   <= q_head_i.op;
            lo_q   <= q_head_i.lo;
            left_q <= q_head_i.count;
            pend_last_q <= 1'b1;
            unique case (q_head_i.op)
              xrng_pkg::OP_CONST: begin
                pend_value_q <= q_head_i.lo;
                state_q      <= ST_EMIT;
              end
              xrng_pkg::OP_RAW64: begin
                gen_q        <= xs_next;
                pend_value_q <= xs_next;
                state_q      <= ST_EMIT;
              end
              xrng_pkg::OP_RAW32: begin
                gen_q        <= xs_next;
                pend_value_q <= {32'b0, xs_next[31:0]};
                state_q      <= ST_EMIT;
              end
              default: begin
                gen_q   <= xs_next;
                state_q <= ST_MOD;
              end
            endcase
          end
        end
        ST_MOD: begin
          if (mod_rsp_i.done) begin
            pend_value_q <= mod_value;
            pend_last_q  <= (op_q != xrng_pkg::OP_LETTERS) || (left_q == 7'd1);
            state_q      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= pend_value_q;
            out_last_q  <= pend_last_q;
            if (more) begin
              left_q  <= left_q - 7'd1;
              gen_q   <= xs_next;
              state_q <= ST_MOD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // seed writes must arrive only while idle; the block itself does not enforce it
      if (cfg_i.valid) begin
        gen_q <= cfg_i.data;
      end
    end
  end

  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.value = out_value_q;
  assign res_o.last  = out_last_q;

endmodule

`default_nettype wire

@@ verif/xrng_draw_checker.sv @@
`timescale 1ns / 1ps

module xrng_draw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [2:0]  cmd_code_i,
  input  logic [63:0] range_low_i,
  input  logic [63:0] range_high_i,
  input  logic [6:0]  letter_count_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [63:0] value_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [63:0] cfg_data_i,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned mismatches_o
);

  localparam int unsigned BURST_CAP = 64;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } draw_t;

  draw_t       expected_draws[$];
  logic [63:0] gen_state;
  int unsigned checked = 0;
  int unsigned mismatches = 0;

  function automatic logic [63:0] advance_state(input logic [63:0] s);
    logic [63:0] v;
    v = s;
    v = v ^ (v << xrng_pkg::SHIFT_A);
    v = v ^ (v >> xrng_pkg::SHIFT_B);
    v = v ^ (v << xrng_pkg::SHIFT_C);
    return v;
  endfunction

  task automatic expect_draw(input logic [63:0] v, input logic is_last);
    draw_t d;
    d.value = v;
    d.last  = is_last;
    expected_draws.push_back(d);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] draw check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_command(input logic [2:0] code, input logic [63:0] lo,
                                 input logic [63:0] hi, input logic [6:0] cnt);
    logic [31:0] lo32, hi32, span32, d32;
    logic [63:0] span64;
    logic [5:0]  idx;
    logic [7:0]  letter;
    int unsigned n;
    lo32 = lo[31:0];
    hi32 = hi[31:0];
    case (code)
      xrng_pkg::CMD_RAW64: begin
        gen_state = advance_state(gen_state);
        expect_draw(gen_state, 1'b1);
      end
      xrng_pkg::CMD_RAW32: begin
        gen_state = advance_state(gen_state);
        expect_draw({32'd0, gen_state[31:0]}, 1'b1);
      end
      xrng_pkg::CMD_RANGED32: begin
        if (lo32 == hi32) begin
          expect_draw({32'd0, lo32}, 1'b1);
        end else begin
          gen_state = advance_state(gen_state);
          span32 = hi32 - lo32;
          d32 = gen_state[31:0] % span32;
          d32 = d32 + lo32;
          expect_draw({32'd0, d32}, 1'b1);
        end
      end
      xrng_pkg::CMD_RANGED64: begin
        if (lo == hi) begin
          expect_draw(lo, 1'b1);
        end else begin
          gen_state = advance_state(gen_state);
          span64 = hi - lo;
          expect_draw((gen_state % span64) + lo, 1'b1);
        end
      end
      xrng_pkg::CMD_LETTERS: begin
        n = (cnt > BURST_CAP) ? BURST_CAP : cnt;
        for (int unsigned i = 0; i < n; i++) begin
          gen_state = advance_state(gen_state);
          d32 = gen_state[31:0] % 32'd52;
          idx = d32[5:0];
          // lower case first, then upper case
          if (idx < xrng_pkg::ALPHABET_HALF) begin
            letter = xrng_pkg::LETTER_LOWER_BASE + {2'b00, idx};
          end else begin
            letter = xrng_pkg::LETTER_UPPER_BASE + {2'b00, idx}
                     - {2'b00, xrng_pkg::ALPHABET_HALF};
          end
          expect_draw({56'd0, letter}, i == n - 1);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      gen_state = xrng_pkg::SEED_RESET;
      expected_draws.delete();
      outstanding_o <= 0;
      checked_o     <= checked;
      mismatches_o  <= mismatches;
    end else begin
      // check results before new requests so an early result is never masked
      if (res_valid_i && res_ready_i) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h last=%b", value_i, last_i));
        end else begin
          want = expected_draws.pop_front();
          if (value_i !== want.value) begin
            report_mismatch($sformatf("result %0d value %h, expected %h",
                                      checked, value_i, want.value));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      checked, last_i, want.last));
          end
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        gen_state = cfg_data_i;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        predict_command(cmd_code_i, range_low_i, range_high_i, letter_count_i);
      end
      outstanding_o <= unsigned'(expected_draws.size());
      checked_o     <= checked;
      mismatches_o  <= mismatches;
    end
  end

endmodule

@@ verif/tb_xorshift64_range_rng_top.sv @@
`timescale 1ns / 1ps

module tb_xorshift64_range_rng_top;

  localparam logic [2:0]  CMD_SPARE_5      = 3'd5;
  localparam logic [2:0]  CMD_SPARE_6      = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7      = 3'd7;
  localparam logic [63:0] ALL_ONES         = '1;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned DRAIN_CYCLES     = 100;
  localparam int unsigned RANDOM_PER_PHASE = 36;
  localparam int unsigned RANDOM_PHASES    = 4;

  typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_SPARSE} sink_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_busy = 1'b0;
  int unsigned hold_left;
  int unsigned mode_left;
  sink_mode_e  sink_mode;
  int unsigned burst_left = 0;
  int unsigned cmds_sent = 0;
  int unsigned seeds_written = 0;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned mismatches;

  xrng_cmd_if cmd_if ();
  xrng_res_if res_if ();
  xrng_cfg_if cfg_if ();

  xorshift64_range_rng_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  xrng_draw_checker u_draw_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cmd_valid_i    (cmd_if.valid),
    .cmd_ready_i    (cmd_if.ready),
    .cmd_code_i     (cmd_if.cmd),
    .range_low_i    (cmd_if.range_low),
    .range_high_i   (cmd_if.range_high),
    .letter_count_i (cmd_if.letter_count),
    .res_valid_i    (res_if.valid),
    .res_ready_i    (res_if.ready),
    .value_i        (res_if.value),
    .last_i         (res_if.last),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_data_i     (cfg_if.data),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .mismatches_o   (mismatches)
  );

  always #6 clk = ~clk;

  // result side: random stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_busy    <= 1'b0;
      mode_left    <= 0;
      sink_mode    <= SINK_OPEN;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
      if (hold_left == 1) begin
        hold_busy <= 1'b0;
      end
    end else if (hold_req && !hold_busy) begin
      res_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_busy    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   res_if.ready <= 1'b1;
        SINK_CHOPPY: res_if.ready <= 1'($urandom_range(0, 1));
        default:     res_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] corner_word(input int unsigned k);
    case (k)
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return ALL_ONES;
      3:       return 64'h8000_0000_0000_0000;
      default: return 64'h0000_0000_FFFF_FFFF;
    endcase
  endfunction

  task automatic send_cmd(input logic [2:0] code, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [6:0] cnt);
    cmd_if.valid        <= 1'b1;
    cmd_if.cmd          <= code;
    cmd_if.range_low    <= lo;
    cmd_if.range_high   <= hi;
    cmd_if.letter_count <= cnt;
    do @(posedge clk); while (!cmd_if.ready);
    cmds_sent++;
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // a request with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= s;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    seeds_written++;
  endtask

  task automatic send_random_cmd(output bit productive);
    int unsigned pick;
    int unsigned gap;
    logic [2:0]  code;
    logic [63:0] lo, hi;
    logic [6:0]  cnt;
    pick = $urandom_range(0, 99);
    lo   = rand_word();
    hi   = rand_word();
    cnt  = 7'($urandom);
    if (pick < 12) begin
      code = xrng_pkg::CMD_RAW64;
    end else if (pick < 22) begin
      code = xrng_pkg::CMD_RAW32;
    end else if (pick < 72) begin
      code = (pick < 47) ? xrng_pkg::CMD_RANGED32 : xrng_pkg::CMD_RANGED64;
      case ($urandom_range(0, 6))
        0: hi = lo;
        1: hi = lo + 64'($urandom_range(1, 1000));
        2: begin
          lo = 64'($urandom_range(0, 100));
          hi = 64'($urandom_range(0, 100));
        end
        3: begin
          lo = corner_word($urandom_range(0, 4));
          hi = corner_word($urandom_range(0, 4));
        end
        4: hi = {$urandom, lo[31:0]};  // same low half, different upper half
        default: begin
        end
      endcase
    end else if (pick < 92) begin
      code = xrng_pkg::CMD_LETTERS;
      case ($urandom_range(0, 19))
        0:       cnt = 7'd0;
        1:       cnt = 7'($urandom_range(65, 127));
        2, 3:    cnt = 7'($urandom_range(9, 64));
        default: cnt = 7'($urandom_range(1, 8));
      endcase
    end else begin
      code = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    end
    productive = (pick < 92) && !(code == xrng_pkg::CMD_LETTERS && cnt == 7'd0);

    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_cmd(code, lo, hi, cnt);
  endtask

  initial begin
    int unsigned counted;
    bit          productive;
    cmd_if.valid        = 1'b0;
    cmd_if.cmd          = xrng_pkg::CMD_RAW64;
    cmd_if.range_low    = '0;
    cmd_if.range_high   = '0;
    cmd_if.letter_count = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners under the reset seed
    send_cmd(xrng_pkg::CMD_RAW64, 64'd0, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_RAW32, ALL_ONES, ALL_ONES, 7'h7F);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'hFFFF_FFFF_1234_5678, 64'h0000_0000_1234_5678, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'd10, 64'd20, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'd100, 64'd5, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'd0, 64'hFFFF_FFFF, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'hFFFF_FFFF, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, ALL_ONES, ALL_ONES, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, 64'h8000_0000_0000_0000, 64'd7, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, 64'd0, ALL_ONES, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, 64'd1, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, ALL_ONES, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_LETTERS, 64'd0, 64'd0, 7'd1);
    send_cmd(xrng_pkg::CMD_LETTERS, 64'd0, 64'd0, 7'd64);
    send_cmd(xrng_pkg::CMD_LETTERS, 64'd0, 64'd0, 7'd65);
    send_cmd(xrng_pkg::CMD_LETTERS, ALL_ONES, ALL_ONES, 7'h7F);
    send_cmd(xrng_pkg::CMD_LETTERS, 64'd0, 64'd0, 7'd0);
    send_cmd(CMD_SPARE_5, ALL_ONES, ALL_ONES, 7'h7F);
    send_cmd(CMD_SPARE_6, 64'd0, 64'd0, 7'd1);
    send_cmd(CMD_SPARE_7, 64'd5, 64'd9, 7'd3);

    // zero seed must stay stuck at zero
    write_seed(64'd0);
    send_cmd(xrng_pkg::CMD_RAW64, 64'd0, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED64, 64'd3, 64'd9, 7'd0);
    send_cmd(xrng_pkg::CMD_LETTERS, 64'd0, 64'd0, 7'd2);

    write_seed(ALL_ONES);
    send_cmd(xrng_pkg::CMD_RAW32, 64'd0, 64'd0, 7'd0);
    send_cmd(xrng_pkg::CMD_RANGED32, 64'd0, 64'd7, 7'd0);

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_seed(rand_word());
        1:       write_seed(64'd1);
        2:       write_seed(xrng_pkg::SEED_RESET);
        default: write_seed(rand_word());
      endcase
      counted = 0;
      if (phase == 1) begin
        // hold the result channel for a long stretch so requests back up
        hold_req <= 1'b1;
        do @(posedge clk); while (!hold_busy);
        hold_req <= 1'b0;
        repeat (12) begin
          send_cmd(xrng_pkg::CMD_RAW64, rand_word(), rand_word(), 7'($urandom));
          counted++;
        end
      end
      while (counted < RANDOM_PER_PHASE) begin
        send_random_cmd(productive);
        if (productive) begin
          counted++;
        end
      end
    end

    wait_idle();
    $display("run covered %0d commands over %0d seed settings, %0d results checked",
             cmds_sent, seeds_written + 1, checked);
    $display("incl. range corners, equal and inverted bounds, spare codes, empty and capped bursts");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
